// ----- hw/rtl/min_priority_queue_linear_scan_macros.svh -----
// Assertion macros for the min priority queue
`ifndef MIN_PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH
`define MIN_PRIORITY_QUEUE_LINEAR_SCAN_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define MPQ_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define MPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hw/rtl/mpq_pkg.sv -----
// Shared constants, codes and controller/datapath interface types
`default_nettype none
package mpq_pkg;
	localparam int unsigned CAPACITY = 128;
	localparam int unsigned DATA_W   = 32;
	localparam int unsigned ADDR_W   = $clog2(CAPACITY);
	localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

	typedef logic [1:0] status_t;
	localparam status_t ST_OK    = 2'd0;
	localparam status_t ST_EMPTY = 2'd1;
	localparam status_t ST_FULL  = 2'd2;

	localparam logic OP_INSERT  = 1'b0;
	localparam logic OP_EXTRACT = 1'b1;

	typedef struct packed {
		logic    ins_wr;
		logic    scan_init;
		logic    scan_step;
		logic    wb;
		logic    out_load;
		logic    out_has_min;
		status_t out_status;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
		logic scan_last;
	} sts_t;
endpackage
`default_nettype wire

// ----- hw/rtl/mpq_ram.sv -----
// Generic single-write, single-read RAM with registered read data
`default_nettype none
module mpq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 128
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/mpq_datapath.sv -----
// Queue datapath: entry store, fill count, scan compare and result registers
`default_nettype none
module mpq_datapath import mpq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire cmd_t              cmd,
	input  wire logic [DATA_W-1:0] value,
	output sts_t                   sts,
	output logic [DATA_W-1:0]      min_value,
	output logic [1:0]             status,
	output logic                   is_empty,
	output logic                   is_full
);
	logic [CNT_W-1:0]  count_q;
	logic [ADDR_W-1:0] idx_q;
	logic              first_q;
	logic              rd_vld_s1;
	logic              first_s1;
	logic [ADDR_W-1:0] idx_s1;
	logic [DATA_W-1:0] low_q;
	logic [ADDR_W-1:0] pos_q;
	logic [DATA_W-1:0] last_val_q;

	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [DATA_W-1:0] wr_data;
	logic [DATA_W-1:0] rd_data;
	logic              take;

	assign wr_en   = cmd.ins_wr | cmd.wb;
	assign wr_addr = cmd.wb ? pos_q : count_q[ADDR_W-1:0];
	assign wr_data = cmd.wb ? last_val_q : value;

	mpq_ram #(.WIDTH(DATA_W), .DEPTH(CAPACITY)) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (cmd.scan_step),
		.rd_addr (idx_q),
		.rd_data (rd_data)
	);

	assign sts.full      = (count_q == CNT_W'(CAPACITY));
	assign sts.empty     = (count_q == '0);
	assign sts.scan_last = (idx_q == '0);

	// scan runs from the top down; strict less keeps the highest-indexed tie
	assign take = first_s1 || ($signed(rd_data) < $signed(low_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			first_q   <= 1'b0;
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_step;
			if (cmd.ins_wr) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.wb) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.scan_init) begin
				first_q <= 1'b1;
			end else if (cmd.scan_step) begin
				first_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			idx_q <= ADDR_W'(count_q - CNT_W'(1));
		end else if (cmd.scan_step) begin
			idx_q <= idx_q - ADDR_W'(1);
		end
		if (cmd.scan_step) begin
			idx_s1   <= idx_q;
			first_s1 <= first_q;
		end
		if (rd_vld_s1) begin
			if (first_s1) begin
				last_val_q <= rd_data;
			end
			if (take) begin
				low_q <= rd_data;
				pos_q <= idx_s1;
			end
		end
		if (cmd.out_load) begin
			min_value <= cmd.out_has_min ? low_q : '0;
			status    <= cmd.out_status;
			is_empty  <= sts.empty;
			is_full   <= sts.full;
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/mpq_ctrl.sv -----
// Queue controller: sequences insert, scan, write-back and result hand-off
`default_nettype none
module mpq_ctrl import mpq_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic op,
	output logic      out_valid,
	input  wire logic out_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);
	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_SCAN  = 5'b00010,
		S_DRAIN = 5'b00100,
		S_WB    = 5'b01000,
		S_DONE  = 5'b10000
	} state_t;

	state_t  state_q, state_d;
	status_t res_status_q;
	logic    res_min_q;
	logic    out_valid_q;
	logic    slot_free;
	logic    accept;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d         = state_q;
		cmd.ins_wr      = 1'b0;
		cmd.scan_init   = 1'b0;
		cmd.scan_step   = 1'b0;
		cmd.wb          = 1'b0;
		cmd.out_load    = 1'b0;
		cmd.out_has_min = res_min_q;
		cmd.out_status  = res_status_q;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					if (op == OP_INSERT) begin
						cmd.ins_wr = !sts.full;
						state_d    = S_DONE;
					end else if (sts.empty) begin
						state_d = S_DONE;
					end else begin
						cmd.scan_init = 1'b1;
						state_d       = S_SCAN;
					end
				end
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (sts.scan_last) begin
					state_d = S_DRAIN;
				end
			end
			// last read word is compared here
			S_DRAIN: state_d = S_WB;
			S_WB: begin
				cmd.wb  = 1'b1;
				state_d = S_DONE;
			end
			S_DONE: begin
				if (slot_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (op == OP_INSERT) begin
				res_status_q <= sts.full ? ST_FULL : ST_OK;
				res_min_q    <= 1'b0;
			end else begin
				res_status_q <= sts.empty ? ST_EMPTY : ST_OK;
				res_min_q    <= !sts.empty;
			end
		end
	end
endmodule
`default_nettype wire

// ----- hw/rtl/min_priority_queue_linear_scan.sv -----
// Min priority queue top: unsorted store, extract scans all entries.
// Insert or refused extract: from accept the controller goes to DONE, which loads the
// result registers once the output slot is free. Extract: SCAN (one RAM read per cycle),
// then DRAIN, WB and DONE. One item in flight; the next item is taken while a result
// waits at the output.
// Reset (arst_n low) empties the queue; stored words are not cleared.
`default_nettype none
`include "min_priority_queue_linear_scan_macros.svh"
module min_priority_queue_linear_scan import mpq_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic              op,
	input  wire logic [DATA_W-1:0] value,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [DATA_W-1:0]      min_value,
	output logic [1:0]             status,
	output logic                   is_empty,
	output logic                   is_full
);
	cmd_t cmd;
	sts_t sts;

	mpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpq_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.value     (value),
		.sts       (sts),
		.min_value (min_value),
		.status    (status),
		.is_empty  (is_empty),
		.is_full   (is_full)
	);

	`MPQ_ASSERT_SAME(a_flags_excl, out_valid, !(is_empty && is_full), "empty and full together")
	`MPQ_ASSERT_SAME(a_empty_refuse, out_valid && (status == ST_EMPTY), is_empty,
		"extract refused while queue not empty")
	`MPQ_ASSERT_SAME(a_full_refuse, out_valid && (status == ST_FULL), is_full,
		"insert refused while queue not full")
	`MPQ_ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready,
		"second item taken before first finished")
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
// Self-checking testbench for the linear-scan min priority queue
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import mpq_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = CAPACITY + 16;

	typedef struct packed {
		logic              op;
		logic [DATA_W-1:0] value;
	} pq_cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] min_value;
		status_t           status;
		logic              is_empty;
		logic              is_full;
	} pq_result_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic              op = OP_INSERT;
	logic [DATA_W-1:0] value = '0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic [DATA_W-1:0] min_value;
	logic [1:0]        status;
	logic              is_empty;
	logic              is_full;

	// shadow of the queue contents
	logic [DATA_W-1:0] pq_words [CAPACITY];
	int                pq_held = 0;

	pq_cmd_t    cmd_backlog [$];
	pq_result_t min_results_due [$];
	int         cmds_total = -1;
	int         cmds_accepted = 0;
	int         mismatches = 0;
	int         cycles = 0;
	int         send_wait = 0;
	int         send_calm = 0;
	int         recv_wait = 0;
	int         recv_calm = 0;
	int         plan_count = 0;

	min_priority_queue_linear_scan i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.value     (value),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.min_value (min_value),
		.status    (status),
		.is_empty  (is_empty),
		.is_full   (is_full)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Applies one item to the shadow queue and returns the result it should give.
	// Scan runs from the top index down and keeps only strictly smaller values,
	// so the highest-indexed minimum is the one removed.
	function automatic pq_result_t pq_apply(input logic cmd_op, input logic [DATA_W-1:0] word);
		pq_result_t r;
		int last;
		int pos;
		logic [DATA_W-1:0] low;
		r = '0;
		r.status = ST_OK;
		if (cmd_op == OP_INSERT) begin
			if (pq_held >= CAPACITY) begin
				r.status = ST_FULL;
			end else begin
				pq_words[pq_held] = word;
				pq_held++;
			end
		end else if (pq_held == 0) begin
			r.status = ST_EMPTY;
		end else begin
			last = pq_held - 1;
			pos = last;
			low = pq_words[last];
			for (int i = last - 1; i >= 0; i--) begin
				if ($signed(pq_words[i]) < $signed(low)) begin
					low = pq_words[i];
					pos = i;
				end
			end
			pq_words[pos] = pq_words[last];
			pq_held = last;
			r.min_value = low;
		end
		r.is_empty = (pq_held == 0);
		r.is_full = (pq_held == CAPACITY);
		return r;
	endfunction

	// gap drawn from 0..11, with occasional calm stretches of no gaps at all
	function automatic int draw_idle(inout int calm);
		if (calm > 0) begin
			calm--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0)
			calm = $urandom_range(8, 40);
		return $urandom_range(0, 11);
	endfunction

	function automatic logic [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0, 1, 2: return DATA_W'($signed($urandom_range(0, 15)) - 8);
			3: begin
				case ($urandom_range(0, 3))
					0: return {1'b1, {(DATA_W-1){1'b0}}};
					1: return {1'b0, {(DATA_W-1){1'b1}}};
					2: return '1;
					default: return '0;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	task automatic add_cmd(input logic cmd_op, input logic [DATA_W-1:0] word);
		pq_cmd_t c;
		c.op = cmd_op;
		c.value = word;
		cmd_backlog.push_back(c);
		if (cmd_op == OP_INSERT && plan_count < CAPACITY)
			plan_count++;
		else if (cmd_op == OP_EXTRACT && plan_count > 0)
			plan_count--;
	endtask

	task automatic add_mixed(input int n, input int insert_pct);
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 99) < insert_pct)
				add_cmd(OP_INSERT, pick_value());
			else
				add_cmd(OP_EXTRACT, $urandom());
		end
	endtask

	task automatic flag_mismatch(input string what);
		$display("[%0t] MISMATCH %s", $time, what);
		mismatches++;
	endtask

	initial begin
		// directed: empty refusal, value extremes, ties, drain past empty
		add_cmd(OP_EXTRACT, '0);
		add_cmd(OP_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
		add_cmd(OP_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
		add_cmd(OP_INSERT, '0);
		add_cmd(OP_INSERT, '1);
		add_cmd(OP_INSERT, DATA_W'(1));
		add_cmd(OP_INSERT, DATA_W'(5));
		add_cmd(OP_INSERT, DATA_W'(5));
		add_cmd(OP_INSERT, DATA_W'(-7));
		add_cmd(OP_INSERT, DATA_W'(-7));
		for (int k = 0; k < 10; k++)
			add_cmd(OP_EXTRACT, '1);

		add_mixed(100, 60);
		// fill to capacity, push against full, hover there, then drain past empty
		while (plan_count < CAPACITY)
			add_cmd(OP_INSERT, pick_value());
		for (int k = 0; k < 3; k++)
			add_cmd(OP_INSERT, pick_value());
		for (int k = 0; k < 4; k++) begin
			add_cmd(OP_EXTRACT, $urandom());
			add_cmd(OP_INSERT, pick_value());
		end
		add_cmd(OP_INSERT, pick_value());
		while (plan_count > 0)
			add_cmd(OP_EXTRACT, $urandom());
		add_cmd(OP_EXTRACT, $urandom());
		add_cmd(OP_EXTRACT, $urandom());
		add_mixed(40, 50);
		add_mixed(40, 35);
		cmds_total = cmd_backlog.size();

		send_wait = draw_idle(send_calm);
		recv_wait = draw_idle(recv_calm);
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (cmds_accepted != cmds_total)
			@(posedge clk);
		while (min_results_due.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

	always @(posedge clk) begin : drive
		logic hold;
		pq_cmd_t nxt;
		if (arst_n) begin
			hold = in_valid;
			if (in_valid && in_ready) begin
				min_results_due.push_back(pq_apply(op, value));
				cmds_accepted++;
				hold = 1'b0;
				send_wait = draw_idle(send_calm);
			end
			if (!hold) begin
				if (send_wait > 0) begin
					send_wait--;
				end else if (cmd_backlog.size() > 0) begin
					nxt = cmd_backlog.pop_front();
					op <= nxt.op;
					value <= nxt.value;
					hold = 1'b1;
				end
			end
			in_valid <= hold;
		end
	end

	always @(posedge clk) begin : observe
		pq_result_t due;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (min_results_due.size() == 0) begin
					flag_mismatch("result with no item outstanding");
				end else begin
					due = min_results_due.pop_front();
					if (min_value !== due.min_value)
						flag_mismatch($sformatf("min_value got %0d want %0d",
							$signed(min_value), $signed(due.min_value)));
					if (status !== due.status)
						flag_mismatch($sformatf("status got %0d want %0d",
							status, due.status));
					if (is_empty !== due.is_empty)
						flag_mismatch($sformatf("is_empty got %b want %b",
							is_empty, due.is_empty));
					if (is_full !== due.is_full)
						flag_mismatch($sformatf("is_full got %b want %b",
							is_full, due.is_full));
				end
				recv_wait = draw_idle(recv_calm);
			end
			if (recv_wait > 0) begin
				recv_wait--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end
endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/mpq_pkg.sv
hw/rtl/mpq_ram.sv
hw/rtl/mpq_datapath.sv
hw/rtl/mpq_ctrl.sv
hw/rtl/min_priority_queue_linear_scan.sv
sim/tb.sv
